// ===== sv/tsr_pkg.sv =====
// Shared constants and types for the triangle span rasterizer.
package tsr_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 4096;
	localparam int ROW_W    = 6;   // span row index
	localparam int COL_W    = 12;  // span column
	localparam int CRD_W    = 13;  // vertex coordinate
	localparam int EXT_W    = 14;  // extent and point width, signed
	localparam int LBL_W    = 16;
	localparam int NR_W     = 7;   // num_rows register
	localparam int NC_W     = 13;  // num_cols register
	localparam int CFG_W    = 13;

	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	typedef struct packed {
		logic signed [EXT_W-1:0] col;
		logic signed [EXT_W-1:0] row;
		logic                    last;
	} point_t;

endpackage

// ===== sv/tsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tsr_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/tsr_edge_stepper.sv =====
// Incremental edge walker: one rounded interpolation point per cycle while adv is high.
module tsr_edge_stepper (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  logic                                  adv,
	input  logic signed [tsr_pkg::CRD_W-1:0]      p_col,
	input  logic signed [tsr_pkg::CRD_W-1:0]      p_row,
	input  logic signed [tsr_pkg::CRD_W-1:0]      q_col,
	input  logic signed [tsr_pkg::CRD_W-1:0]      q_row,
	output tsr_pkg::point_t                       pt
);

	localparam int EW = tsr_pkg::EXT_W;

	// quotient tracked as floor with remainder in [0, 2L); truncation fixed at output
	logic signed [EW-1:0] qx_q, qy_q;
	logic signed [EW+2:0] rx_q, ry_q;
	logic signed [EW+1:0] dlx_q, dly_q;
	logic [EW:0]          den_q;
	logic [EW-1:0]        len_q, cnt_q;

	logic signed [EW-1:0] x1, y1, x2, y2, ddx, ddy;
	logic [EW-1:0]        adx, ady, len_n;
	logic signed [EW+2:0] nrx, nry, dens;

	always_comb begin
		if (p_row < q_row) begin
			x1 = EW'(p_col); y1 = EW'(p_row); x2 = EW'(q_col); y2 = EW'(q_row);
		end else begin
			x1 = EW'(q_col); y1 = EW'(q_row); x2 = EW'(p_col); y2 = EW'(p_row);
		end
		ddx   = x2 - x1;
		ddy   = y2 - y1;
		adx   = ddx[EW-1] ? EW'(-ddx) : ddx;
		ady   = ddy[EW-1] ? EW'(-ddy) : ddy;
		len_n = (adx > ady) ? adx : ady;
		dens  = $signed({2'b00, den_q});
		nrx   = rx_q + (EW+3)'(dlx_q);
		nry   = ry_q + (EW+3)'(dly_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (adv) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			len_q <= len_n;
			den_q <= {len_n, 1'b0};
			qx_q  <= x2;
			qy_q  <= y2;
			rx_q  <= (EW+3)'(len_n);
			ry_q  <= (EW+3)'(len_n);
			dlx_q <= (EW+2)'($signed({x1 - x2, 1'b0}));
			dly_q <= (EW+2)'($signed({y1 - y2, 1'b0}));
		end else if (adv) begin
			if (nrx >= dens) begin
				rx_q <= nrx - dens; qx_q <= qx_q + 1'b1;
			end else if (nrx < 0) begin
				rx_q <= nrx + dens; qx_q <= qx_q - 1'b1;
			end else begin
				rx_q <= nrx;
			end
			if (nry >= dens) begin
				ry_q <= nry - dens; qy_q <= qy_q + 1'b1;
			end else if (nry < 0) begin
				ry_q <= nry + dens; qy_q <= qy_q - 1'b1;
			end else begin
				ry_q <= nry;
			end
		end
	end

	always_comb begin
		pt.col  = qx_q + EW'((qx_q < 0) && (rx_q != 0));
		pt.row  = qy_q + EW'((qy_q < 0) && (ry_q != 0));
		pt.last = (cnt_q == len_q);
	end

endmodule

// ===== sv/triangle_span_rasterizer_unit.sv =====
// Triangle span rasterizer: takes one triangle word at a time and emits one span word per
// covered image row, top to bottom, the last flagged. Per-row column extents live in two
// 64-entry RAMs. An item runs setup, a clear of the covered rows, a load and a walk per
// edge, a drain, then a read and a check per row and a final step, which wait out output
// stalls; the edge walk goes one point per cycle through the RAMs' read-modify-write.
// No input is taken until the last span of the previous triangle is in the output register.
module triangle_span_rasterizer_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [tsr_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [tsr_pkg::CRD_W-1:0]       vertex_a_col,
	input  logic signed [tsr_pkg::CRD_W-1:0]       vertex_a_row,
	input  logic signed [tsr_pkg::CRD_W-1:0]       vertex_b_col,
	input  logic signed [tsr_pkg::CRD_W-1:0]       vertex_b_row,
	input  logic signed [tsr_pkg::CRD_W-1:0]       vertex_c_col,
	input  logic signed [tsr_pkg::CRD_W-1:0]       vertex_c_row,
	input  logic [tsr_pkg::LBL_W-1:0]              fill_label,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [tsr_pkg::ROW_W-1:0]              span_row,
	output logic [tsr_pkg::COL_W-1:0]              span_start,
	output logic [tsr_pkg::COL_W-1:0]              span_end,
	output logic [tsr_pkg::LBL_W-1:0]              span_label,
	output logic                                   last_span
);

	localparam int EW = tsr_pkg::EXT_W;
	localparam int RW = tsr_pkg::ROW_W;
	localparam int CW = tsr_pkg::COL_W;
	localparam int VW = tsr_pkg::CRD_W;

	typedef enum logic [3:0] {
		S_IDLE, S_SETUP, S_CLEAR, S_LOAD, S_WALK, S_DRAIN, S_ERD, S_ECHK, S_FINAL
	} state_t;

	state_t state_q;

	logic [tsr_pkg::NR_W-1:0] nrows_q, rows_eff;
	logic [tsr_pkg::NC_W-1:0] ncols_q, cols_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrows_q <= tsr_pkg::NR_W'(tsr_pkg::MAX_ROWS);
			ncols_q <= tsr_pkg::NC_W'(tsr_pkg::MAX_COLS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsr_pkg::REG_NUM_ROWS: nrows_q <= cfg_data[tsr_pkg::NR_W-1:0];
				tsr_pkg::REG_NUM_COLS: ncols_q <= cfg_data[tsr_pkg::NC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (nrows_q == '0)
			rows_eff = tsr_pkg::NR_W'(1);
		else if (nrows_q > tsr_pkg::NR_W'(tsr_pkg::MAX_ROWS))
			rows_eff = tsr_pkg::NR_W'(tsr_pkg::MAX_ROWS);
		else
			rows_eff = nrows_q;
		if (ncols_q == '0)
			cols_eff = tsr_pkg::NC_W'(1);
		else if (ncols_q > tsr_pkg::NC_W'(tsr_pkg::MAX_COLS))
			cols_eff = tsr_pkg::NC_W'(tsr_pkg::MAX_COLS);
		else
			cols_eff = ncols_q;
	end

	// triangle registers
	logic signed [VW-1:0] ac_q, ar_q, bc_q, br_q, cc_q, cr_q;
	logic [tsr_pkg::LBL_W-1:0] lbl_q;
	logic [RW-1:0] row_q, bot_q;
	logic [1:0]    edge_q;

	// stepper
	logic stp_load, stp_adv;
	logic signed [VW-1:0] ep_c, ep_r, eq_c, eq_r;
	tsr_pkg::point_t pt;

	always_comb begin
		unique case (edge_q)
			2'd0: begin ep_c = ac_q; ep_r = ar_q; eq_c = bc_q; eq_r = br_q; end
			2'd1: begin ep_c = bc_q; ep_r = br_q; eq_c = cc_q; eq_r = cr_q; end
			default: begin ep_c = cc_q; ep_r = cr_q; eq_c = ac_q; eq_r = ar_q; end
		endcase
	end

	assign stp_load = (state_q == S_LOAD);
	assign stp_adv  = (state_q == S_WALK);

	tsr_edge_stepper u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (stp_load),
		.adv    (stp_adv),
		.p_col  (ep_c),
		.p_row  (ep_r),
		.q_col  (eq_c),
		.q_row  (eq_r),
		.pt     (pt)
	);

	// extent RAMs
	logic          we;
	logic [RW-1:0] waddr, raddr;
	logic [EW-1:0] wmin, wmax, rmin, rmax;

	tsr_ram #(.WIDTH(EW), .DEPTH(tsr_pkg::MAX_ROWS)) u_min_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wmin), .raddr(raddr), .rdata(rmin)
	);
	tsr_ram #(.WIDTH(EW), .DEPTH(tsr_pkg::MAX_ROWS)) u_max_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wmax), .raddr(raddr), .rdata(rmax)
	);

	// point pipeline: read issued, then merge and write back
	logic                 pt_in;
	logic                 v_s1;
	logic [RW-1:0]        a_s1;
	logic signed [EW-1:0] c_s1;
	logic                 fv_q;
	logic [RW-1:0]        fa_q;
	logic signed [EW-1:0] fmin_q, fmax_q;
	logic signed [EW-1:0] omin, omax, nmin, nmax;

	assign pt_in = (state_q == S_WALK) && !pt.row[EW-1]
		&& (pt.row < $signed({1'b0, rows_eff}));

	always_comb begin
		// forward the write of the point just before
		if (fv_q && (fa_q == a_s1)) begin
			omin = fmin_q; omax = fmax_q;
		end else begin
			omin = $signed(rmin); omax = $signed(rmax);
		end
		nmin = (c_s1 < omin) ? c_s1 : omin;
		nmax = (c_s1 > omax) ? c_s1 : omax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fv_q <= 1'b0;
		end else begin
			v_s1 <= pt_in;
			fv_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= pt.row[RW-1:0];
		c_s1   <= pt.col;
		fa_q   <= a_s1;
		fmin_q <= nmin;
		fmax_q <= nmax;
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = row_q;
			wmin  = EW'(cols_eff) + EW'(1);
			wmax  = '1;
		end else begin
			we    = v_s1;
			waddr = a_s1;
			wmin  = nmin;
			wmax  = nmax;
		end
		raddr = (state_q == S_WALK) ? pt.row[RW-1:0] : row_q;
	end

	// span check
	logic signed [EW-1:0] sp_s, sp_e, clim;
	logic                 sp_ok, out_free;

	always_comb begin
		clim  = EW'(cols_eff) - EW'(1);
		sp_s  = ($signed(rmin) < 0) ? '0 : $signed(rmin);
		sp_e  = ($signed(rmax) > clim) ? clim : $signed(rmax);
		sp_ok = (sp_s <= sp_e);
	end

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// triangle bounds
	logic signed [VW-1:0] tmin, tmax;
	logic                 empty;

	always_comb begin
		tmin = ar_q;
		if (br_q < tmin) tmin = br_q;
		if (cr_q < tmin) tmin = cr_q;
		tmax = ar_q;
		if (br_q > tmax) tmax = br_q;
		if (cr_q > tmax) tmax = cr_q;
		empty = tmax[VW-1] || (tmin >= $signed(VW'(rows_eff)));
	end

	// pending span, held until the next one shows whether it is the last
	logic          pv_q;
	logic [RW-1:0] prow_q;
	logic [CW-1:0] ps_q, pe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			pv_q      <= 1'b0;
			row_q     <= '0;
			edge_q    <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					edge_q <= '0;
					pv_q   <= 1'b0;
					row_q  <= tmin[VW-1] ? '0 : tmin[RW-1:0];
					if (empty) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					if (row_q == bot_q) begin
						state_q <= S_LOAD;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				S_LOAD: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (pt.last) begin
						if (edge_q == 2'd2) begin
							state_q <= S_DRAIN;
						end else begin
							edge_q  <= edge_q + 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				S_DRAIN: begin
					row_q   <= tmin[VW-1] ? '0 : tmin[RW-1:0];
					state_q <= S_ERD;
				end
				S_ERD: begin
					state_q <= S_ECHK;
				end
				S_ECHK: begin
					if (!(sp_ok && pv_q && !out_free)) begin
						if (sp_ok) begin
							if (pv_q) begin
								out_valid  <= 1'b1;
								span_row   <= prow_q;
								span_start <= ps_q;
								span_end   <= pe_q;
								span_label <= lbl_q;
								last_span  <= 1'b0;
							end
							pv_q   <= 1'b1;
							prow_q <= row_q;
							ps_q   <= sp_s[CW-1:0];
							pe_q   <= sp_e[CW-1:0];
						end
						if (row_q == bot_q) begin
							state_q <= S_FINAL;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				S_FINAL: begin
					if (!pv_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid  <= 1'b1;
						span_row   <= prow_q;
						span_start <= ps_q;
						span_end   <= pe_q;
						span_label <= lbl_q;
						last_span  <= 1'b1;
						pv_q       <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			ac_q  <= vertex_a_col;
			ar_q  <= vertex_a_row;
			bc_q  <= vertex_b_col;
			br_q  <= vertex_b_row;
			cc_q  <= vertex_c_col;
			cr_q  <= vertex_c_row;
			lbl_q <= fill_label;
		end
		if (state_q == S_SETUP) begin
			bot_q <= (tmax >= $signed(VW'(rows_eff))) ? RW'(rows_eff - 1'b1) : tmax[RW-1:0];
		end
	end

endmodule
